@@ sv/table_backoff_with_jitter_core_assert.svh @@
// ----------------------------------------------------------------------------
// table_backoff_with_jitter_core_assert.svh
// Assertion macros for the backoff core, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TABLE_BACKOFF_WITH_JITTER_CORE_ASSERT_SVH
`define TABLE_BACKOFF_WITH_JITTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TBJ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tbj assertion failed");
`define TBJ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbj sequence assertion failed");
`else
`define TBJ_ASSERT(lbl, prop)
`define TBJ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/tbj_pkg.sv @@
// ----------------------------------------------------------------------------
// tbj_pkg
// Shared constants, codes and types of the table backoff core.
// ----------------------------------------------------------------------------
package tbj_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ENT_W       = 16;
  localparam int RND_W       = 32;
  localparam int LEN_W       = 5;
  localparam int CLS_W       = 2;
  localparam int VAL_W       = ENT_W + 1;
  localparam int CNT_W       = $clog2(RND_W);

  localparam logic [CLS_W-1:0] CLS_NONE    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_INVALID = 2'd3;

  typedef enum logic [1:0] {
    ACT_OUTCOME = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_LOAD    = 2'd2,
    ACT_RESET   = 2'd3
  } tbj_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_CALC
  } tbj_state_e;

  typedef struct packed {
    logic             start;
    logic [RND_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } tbj_mod_req_t;

  typedef struct packed {
    logic             done;
    logic [ENT_W-1:0] rem;
  } tbj_mod_rsp_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [ENT_W-1:0] decay;
    logic [ENT_W-1:0] backoff;
  } tbj_wr_t;

endpackage

@@ sv/tbj_table.sv @@
// ----------------------------------------------------------------------------
// tbj_table
// Backoff and decay table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tbj_table (
  input  logic                          clk_i,
  input  tbj_pkg::tbj_wr_t              wr_i,
  input  logic [tbj_pkg::IDX_W-1:0]     raddr_a_i,
  input  logic [tbj_pkg::IDX_W-1:0]     raddr_b_i,
  output logic [2*tbj_pkg::ENT_W-1:0]   rdata_a_o,
  output logic [2*tbj_pkg::ENT_W-1:0]   rdata_b_o
);
  import tbj_pkg::*;

  logic [2*ENT_W-1:0] mem_q [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= {wr_i.decay, wr_i.backoff};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ sv/tbj_mod_serial.sv @@
// ----------------------------------------------------------------------------
// tbj_mod_serial
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tbj_mod_serial (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tbj_pkg::tbj_mod_req_t req_i,
  output tbj_pkg::tbj_mod_rsp_t rsp_o
);
  import tbj_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RND_W-1:0] dvd_q, dvd_d;
  logic [VAL_W-1:0] dvs_q, dvs_d;
  logic [ENT_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] trial;

  always_comb begin
    trial  = {rem_q, dvd_q[RND_W-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[RND_W-2:0], 1'b0};
      if (trial >= dvs_q) begin
        rem_d = ENT_W'(trial - dvs_q);
      end else begin
        rem_d = trial[ENT_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(RND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ sv/table_backoff_with_jitter_core.sv @@
// ----------------------------------------------------------------------------
// table_backoff_with_jitter_core
// Table driven retry backoff with decay countdown and jittered penalty.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the action (report
// outcome, tick, load table entry, reset penalty), tdata the operands.
// Every request yields exactly one result on the m_axis channel with the
// table index, the jittered penalty, the countdown flag and the stored class.
// The user writes table_length through cfg_we_i / cfg_wdata_i only while idle;
// the core does not enforce it. From acceptance until m_axis_tvalid rises a
// request passes state update, table read, then a 32-step bit-serial
// remainder of the random word by (previous entry + 1), which sets the pace,
// then the final add and clamp. One request is in flight at a time; the next
// one is taken the cycle after the result is registered.
// The output register holds a result while the receiver stalls; the next
// request is still accepted and runs up to its final step, where it waits.
// Reset clears index, class and countdown and sets table_length to 1; the
// table holds no defined data until loaded.
// ----------------------------------------------------------------------------
`include "table_backoff_with_jitter_core_assert.svh"

module table_backoff_with_jitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,    // table_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // outcome_class[1:0], random_value[33:2], entry_index[37:34],
  // backoff_entry[53:38], decay_entry[69:54], zero[71:70]
  input  logic [71:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // penalty_index[3:0], penalty_value[20:4], cooldown_armed[21],
  // current_class[23:22]
  output logic [23:0] m_axis_tdata
);
  import tbj_pkg::*;

  tbj_state_e       state_q, state_d;
  tbj_action_e      act_q;
  logic [CLS_W-1:0] cls_q;
  logic [RND_W-1:0] rnd_q;
  logic [IDX_W-1:0] ei_q;
  logic [ENT_W-1:0] be_q, de_q;

  logic [LEN_W-1:0] len_q;
  logic [IDX_W-1:0] level_q, level_d;
  logic [CLS_W-1:0] class_q, class_d;
  logic             run_q, run_d;
  logic [ENT_W-1:0] ticks_q, ticks_d;
  logic             arm_q, arm_d;

  logic [ENT_W-1:0] pen0_q, cur_q, prev_q;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [VAL_W-1:0] out_val_q;
  logic             out_armed_q;
  logic [CLS_W-1:0] out_cls_q;

  logic             in_acc, slot_free, exec_en, load_en, out_load;
  logic [IDX_W-1:0] top, lvl_dec;
  logic [LEN_W-1:0] lvl_next;
  logic [ENT_W-1:0] prev_w, half;
  logic [VAL_W-1:0] sum, diff, val_w;

  tbj_wr_t          wr;
  logic [2*ENT_W-1:0] rd_a, rd_b;
  tbj_mod_req_t     mod_req;
  tbj_mod_rsp_t     mod_rsp;

  tbj_table u_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .raddr_a_i (level_q),
    .raddr_b_i (level_q - 1'b1),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  tbj_mod_serial u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_READ;
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (mod_rsp.done) state_d = ST_CALC;
      ST_CALC: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    exec_en       = 1'b0;
    load_en       = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: exec_en = 1'b1;
      ST_LOAD: load_en = 1'b1;
      ST_CALC: out_load = slot_free;
      default: ;
    endcase
  end

  // last entry in use, length 0 acting as 1
  always_comb begin
    if (len_q == '0) begin
      top = '0;
    end else if (len_q >= LEN_W'(TABLE_DEPTH)) begin
      top = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      top = IDX_W'(len_q - LEN_W'(1));
    end
  end

  assign lvl_next = {1'b0, level_q} + LEN_W'(1);

  always_comb begin
    level_d = level_q;
    class_d = class_q;
    run_d   = run_q;
    ticks_d = ticks_q;
    arm_d   = 1'b0;
    lvl_dec = level_q;
    case (act_q)
      ACT_OUTCOME: begin
        if (cls_q != CLS_INVALID) begin
          class_d = cls_q;
          if (cls_q != CLS_NONE) begin
            level_d = (lvl_next < {1'b0, top}) ? lvl_next[IDX_W-1:0] : top;
            run_d   = 1'b1;
            arm_d   = 1'b1;
          end
        end
      end
      ACT_TICK: begin
        if (run_q) begin
          if (ticks_q <= ENT_W'(1)) begin
            if (class_q == CLS_NONE && level_q != '0) begin
              lvl_dec = level_q - 1'b1;
            end
            level_d = lvl_dec;
            run_d   = (lvl_dec != '0);
            arm_d   = (lvl_dec != '0);
            ticks_d = '0;
          end else begin
            ticks_d = ticks_q - 1'b1;
          end
        end
      end
      ACT_RESET: begin
        level_d = '0;
        run_d   = 1'b0;
        ticks_d = '0;
      end
      default: ;
    endcase
  end

  // every 4-bit entry_index is inside the table
  assign wr.we      = exec_en && (act_q == ACT_LOAD);
  assign wr.addr    = ei_q;
  assign wr.decay   = de_q;
  assign wr.backoff = be_q;

  assign prev_w           = (level_q == '0) ? '0 : rd_b[ENT_W-1:0];
  assign mod_req.start    = load_en;
  assign mod_req.dividend = rnd_q;
  assign mod_req.divisor  = {1'b0, prev_w} + VAL_W'(1);

  always_comb begin
    half = {1'b0, prev_q[ENT_W-1:1]};
    if (half == '0) half = ENT_W'(1);
    sum  = {1'b0, cur_q} + {1'b0, mod_rsp.rem};
    diff = sum - {1'b0, half};
    val_w = (sum >= {1'b0, half}) ? diff : '0;
    if (val_w < {1'b0, pen0_q}) val_w = {1'b0, pen0_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_W'(1);
      level_q     <= '0;
      class_q     <= CLS_NONE;
      run_q       <= 1'b0;
      ticks_q     <= '0;
      arm_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) len_q <= cfg_wdata_i;
      if (exec_en) begin
        level_q <= level_d;
        class_q <= class_d;
        run_q   <= run_d;
        ticks_q <= ticks_d;
        arm_q   <= arm_d;
      end else if (load_en && arm_q) begin
        ticks_q <= rd_a[2*ENT_W-1:ENT_W];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= tbj_action_e'(s_axis_tuser);
      cls_q <= s_axis_tdata[1:0];
      rnd_q <= s_axis_tdata[33:2];
      ei_q  <= s_axis_tdata[37:34];
      be_q  <= s_axis_tdata[53:38];
      de_q  <= s_axis_tdata[69:54];
    end
    if (wr.we && wr.addr == '0) pen0_q <= be_q;
    if (load_en) begin
      cur_q  <= rd_a[ENT_W-1:0];
      prev_q <= prev_w;
    end
    if (out_load) begin
      out_idx_q   <= level_q;
      out_val_q   <= val_w;
      out_armed_q <= run_q;
      out_cls_q   <= class_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cls_q, out_armed_q, out_val_q, out_idx_q};

  `TBJ_ASSERT(a_done_in_div, mod_rsp.done |-> state_q == ST_DIV)
  `TBJ_ASSERT(a_rem_below_divisor, mod_rsp.done |-> mod_rsp.rem <= prev_q)
  `TBJ_ASSERT_NEXT(a_accept_to_exec, in_acc, state_q == ST_EXEC)

endmodule
